/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/spsdd_pkg.sv */
// types and constants of the stereo peak span direction detector
`timescale 1ns / 1ps

package spsdd_pkg;

  localparam int RAW_W   = 16;
  localparam int LEVEL_W = 14;
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 16;
  localparam int HOLD_W  = 6;
  localparam int DIR_W   = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = RAW_W + LEVEL_W;

  typedef logic [RAW_W-1:0]   raw_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [WIN_W-1:0]   win_t;
  typedef logic [HOLD_W-1:0]  hold_t;
  typedef logic [DIR_W-1:0]   dir_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DATA_W-1:0]  data_t;

  typedef struct packed {
    logic   gate;
    level_t left;
    level_t right;
    time_t  now;
  } sample_t;

  localparam level_t SCALE_MUL = 14'd10000;
  localparam raw_t   SCALE_DIV = 16'hFFFF;

  localparam dir_t DIR_NONE  = 2'd0;
  localparam dir_t DIR_LEFT  = 2'd1;
  localparam dir_t DIR_RIGHT = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_HOLDOFF   = 2'd2;

  localparam level_t THRESHOLD_RST = 14'd5000;
  localparam win_t   WINDOW_RST    = 16'd1000;
  localparam hold_t  HOLDOFF_RST   = 6'd20;
  localparam level_t PEAK_HI_RST   = '0;
  localparam level_t PEAK_LO_RST   = '1;
  localparam hold_t  HOLD_ARMED    = '0;
  localparam hold_t  HOLD_ONE      = 6'd1;

endpackage

/* rtl/core/spsdd_scale.sv */
// scales a raw converter sample to 0..10000 by floor(raw * 10000 / 65535)
`timescale 1ns / 1ps

module spsdd_scale (
  input  spsdd_pkg::raw_t   raw,
  output spsdd_pkg::level_t level
);
  import spsdd_pkg::*;

  logic [PROD_W-1:0] prod;
  level_t            q0;
  logic [RAW_W:0]    r0;

  always_comb begin
    prod  = PROD_W'(raw) * PROD_W'(SCALE_MUL);
    q0    = prod[PROD_W-1:RAW_W];
    r0    = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(q0);
    level = q0 + LEVEL_W'(r0 >= {1'b0, SCALE_DIV});
  end

endmodule

/* rtl/core/stereo_peak_span_direction_detector_top.sv */
// a word accepted at the input passes the s1, s2 and output registers in turn
// throughput: one word per cycle, no bubbles while the output is taken
// the last stage updates the peak trackers, window and holdoff for each gated word
// reset: synchronous active-low rst_n clears the pipeline, trackers and registers
// to their defaults (threshold 5000, window 1000 ms, holdoff 20)
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stereo_peak_span_direction_detector_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_gate_active,
  input  spsdd_pkg::raw_t    in_left_raw,
  input  spsdd_pkg::raw_t    in_right_raw,
  input  spsdd_pkg::time_t   in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output spsdd_pkg::level_t  out_left_level,
  output spsdd_pkg::level_t  out_right_level,
  output spsdd_pkg::dir_t    out_direction,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  spsdd_pkg::addr_t   paddr,
  input  spsdd_pkg::data_t   pwdata,
  output spsdd_pkg::data_t   prdata,
  output logic               pready
);
  import spsdd_pkg::*;

  // configuration
  level_t thr_r;
  win_t   win_r;
  hold_t  hoff_r;
  logic   cfg_wr;

  // pipeline
  logic    s1_v_r, s2_v_r, out_v_r;
  logic    s1_load, s2_load, out_load;
  logic    s1_gate_r;
  raw_t    s1_left_r, s1_right_r;
  time_t   s1_now_r;
  level_t  sc_left, sc_right;
  sample_t s2_r, s2_nxt;
  level_t  out_left_r, out_right_r;
  dir_t    out_dir_r;

  // tracker state
  level_t lhi_r, llo_r, rhi_r, rlo_r;
  level_t lhi_nxt, llo_nxt, rhi_nxt, rlo_nxt;
  time_t  ws_r, ws_nxt;
  hold_t  hold_r, hold_nxt, hold_step;
  time_t  elapsed;
  level_t lspan, rspan;
  logic   win_hit, exc_l, exc_r;
  dir_t   dir_nxt;
  level_t lvl_l_nxt, lvl_r_nxt;
  logic   lvl_zero;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      win_r  <= WINDOW_RST;
      hoff_r <= HOLDOFF_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_THRESHOLD: thr_r  <= pwdata[LEVEL_W-1:0];
        REG_WINDOW:    win_r  <= pwdata[WIN_W-1:0];
        REG_HOLDOFF:   hoff_r <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD: prdata = DATA_W'(thr_r);
      REG_WINDOW:    prdata = DATA_W'(win_r);
      REG_HOLDOFF:   prdata = DATA_W'(hoff_r);
      default:       prdata = '0;
    endcase
  end

  // handshake
  assign out_load = s2_v_r & (~out_v_r | out_ready);
  assign s2_load  = s1_v_r & (~s2_v_r | out_load);
  assign in_ready = ~s1_v_r | s2_load;
  assign s1_load  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_load | (s1_v_r & ~s2_load);
      s2_v_r  <= s2_load | (s2_v_r & ~out_load);
      out_v_r <= out_load | (out_v_r & ~out_ready);
    end
  end

  // input word
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_gate_r  <= in_gate_active;
      s1_left_r  <= in_left_raw;
      s1_right_r <= in_right_raw;
      s1_now_r   <= in_now_ms;
    end
  end

  spsdd_scale u_scale_l (
    .raw   (s1_left_r),
    .level (sc_left)
  );

  spsdd_scale u_scale_r (
    .raw   (s1_right_r),
    .level (sc_right)
  );

  assign s2_nxt = {s1_gate_r, sc_left, sc_right, s1_now_r};

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_r <= s2_nxt;
    end
  end

  // tracker update
  always_comb begin
    if (hold_r == HOLD_ARMED) begin
      hold_step = HOLD_ARMED;
    end else if (hold_r >= hoff_r) begin
      hold_step = HOLD_ARMED;
    end else begin
      hold_step = hold_r + HOLD_ONE;
    end

    lhi_nxt = (s2_r.left > lhi_r) ? s2_r.left : lhi_r;
    llo_nxt = (s2_r.left < llo_r) ? s2_r.left : llo_r;
    rhi_nxt = (s2_r.right > rhi_r) ? s2_r.right : rhi_r;
    rlo_nxt = (s2_r.right < rlo_r) ? s2_r.right : rlo_r;

    elapsed  = s2_r.now - ws_r;
    win_hit  = elapsed >= TIME_W'(win_r);
    lspan    = lhi_nxt - llo_nxt;
    rspan    = rhi_nxt - rlo_nxt;
    exc_l    = lspan > thr_r;
    exc_r    = rspan > thr_r;
    ws_nxt   = ws_r;
    hold_nxt = hold_step;
    dir_nxt  = DIR_NONE;

    if (win_hit) begin
      ws_nxt = s2_r.now;
      if (exc_l | exc_r) begin
        if (hold_step == HOLD_ARMED) begin
          dir_nxt  = exc_l ? DIR_LEFT : DIR_RIGHT;
          hold_nxt = HOLD_ONE;
        end
        lhi_nxt = s2_r.left;
        llo_nxt = s2_r.left;
        rhi_nxt = s2_r.right;
        rlo_nxt = s2_r.right;
      end
    end

    lvl_l_nxt = s2_r.left;
    lvl_r_nxt = s2_r.right;
    if (!s2_r.gate) begin
      dir_nxt   = DIR_NONE;
      lvl_l_nxt = '0;
      lvl_r_nxt = '0;
    end
  end

  assign lvl_zero = (lvl_l_nxt == '0) && (lvl_r_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhi_r  <= PEAK_HI_RST;
      llo_r  <= PEAK_LO_RST;
      rhi_r  <= PEAK_HI_RST;
      rlo_r  <= PEAK_LO_RST;
      ws_r   <= '0;
      hold_r <= HOLD_ARMED;
    end else if (out_load && s2_r.gate) begin
      lhi_r  <= lhi_nxt;
      llo_r  <= llo_nxt;
      rhi_r  <= rhi_nxt;
      rlo_r  <= rlo_nxt;
      ws_r   <= ws_nxt;
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= lvl_l_nxt;
      out_right_r <= lvl_r_nxt;
      out_dir_r   <= dir_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_left_level  = out_left_r;
  assign out_right_level = out_right_r;
  assign out_direction   = out_dir_r;

  `ASSERT_IMP(a_event_disarms, out_load && (dir_nxt != DIR_NONE), hold_nxt == HOLD_ONE)
  `ASSERT_IMP(a_ungated_zero, out_load && !s2_r.gate, (dir_nxt == DIR_NONE) && lvl_zero)
  `ASSERT_NEXT(a_stall_freezes_window, out_v_r && !out_ready, $stable(ws_r) && $stable(hold_r))
  `ASSERT_NEXT(a_stall_freezes_peak, out_v_r && !out_ready, $stable(lhi_r) && $stable(llo_r))

endmodule
